@@ hdl/kws_pkg.sv @@
// ----------------------------------------------------------------------------
// kws_pkg: shared types and constants of the k-window stream sorter
// Holds the field widths, the controller state type and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kws_pkg;

  localparam int VALUE_W = 32;
  localparam int K_W     = 4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_MOVE,
    ST_EMIT,
    ST_STORE
  } kws_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic acc;
    logic scan_rd;
    logic tail_rd;
    logic move;
    logic out_load;
    logic out_last;
    logic store;
  } kws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic need_release;
    logic fill_zero;
    logic scan_last;
    logic out_free;
    logic is_final;
  } kws_status_t;

endpackage

@@ hdl/kws_in_if.sv @@
// ----------------------------------------------------------------------------
// kws_in_if: input channel of the k-window stream sorter
// Carries one value per item and the flag that marks the final value.
// ----------------------------------------------------------------------------
interface kws_in_if;

  logic                               valid;
  logic                               ready;
  logic signed [kws_pkg::VALUE_W-1:0] value;
  logic                               is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);

endinterface

@@ hdl/kws_out_if.sv @@
// ----------------------------------------------------------------------------
// kws_out_if: result channel of the k-window stream sorter
// Carries one released value per item and the flag on the last result.
// ----------------------------------------------------------------------------
interface kws_out_if;

  logic                               valid;
  logic                               ready;
  logic signed [kws_pkg::VALUE_W-1:0] sorted_value;
  logic                               last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);

endinterface

@@ hdl/kws_datapath.sv @@
// ----------------------------------------------------------------------------
// kws_datapath: window store, minimum search and output register
// Holds the window in a memory with a registered read port, scans it one
// entry a cycle for the minimum and fills the hole with the last entry.
// ----------------------------------------------------------------------------
module kws_datapath #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [kws_pkg::K_W-1:0] cfg_wr_data,
  input  kws_pkg::kws_cmd_t     cmd,
  output kws_pkg::kws_status_t  status,
  kws_in_if.sink                din,
  kws_out_if.source             dout
);
  import kws_pkg::*;

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int LW = (CW > K_W + 1) ? CW : K_W + 1;

  logic signed [VALUE_W-1:0] mem [WINDOW_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [AW-1:0]             rd_addr;

  logic [K_W-1:0]            window_k;
  logic [CW-1:0]             fill;
  logic [AW-1:0]             scan_idx;
  logic                      cmp_pend;
  logic [AW-1:0]             cmp_idx;
  logic signed [VALUE_W-1:0] best;
  logic [AW-1:0]             best_idx;
  logic signed [VALUE_W-1:0] value_q;
  logic                      final_q;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;
  logic                      fill_full;
  logic [LW-1:0]             fill_ext;
  logic [LW-1:0]             cap_k;

  // Window capacity is window_k+1, limited by the store depth.
  assign fill_full = (fill == CW'(WINDOW_DEPTH));
  assign fill_ext  = LW'(fill);
  assign cap_k     = LW'(window_k) + LW'(1);

  // Status toward the controller.
  assign status.in_valid     = din.valid;
  assign status.need_release = (fill != '0) && ((fill_ext >= cap_k) || fill_full);
  assign status.fill_zero    = (fill == '0);
  assign status.scan_last    = (CW'(scan_idx) == fill - CW'(1));
  assign status.out_free     = !out_valid || dout.ready;
  assign status.is_final     = final_q;

  // Channel outputs.
  assign din.ready          = cmd.in_ready;
  assign dout.valid         = out_valid;
  assign dout.sorted_value  = out_value;
  assign dout.last_out      = out_last;

  // The tail read fetches the last entry; otherwise the running index is read.
  assign rd_addr = cmd.tail_rd ? AW'(fill - CW'(1)) : scan_idx;

  // Window memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.move) begin
      mem[best_idx] <= rd_data;
    end else if (cmd.store && !fill_full) begin
      mem[AW'(fill)] <= value_q;
    end
  end

  // Control registers: configuration, fill count, scan state, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_k  <= '0;
      fill      <= '0;
      scan_idx  <= '0;
      cmp_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_k <= cfg_wr_data;
      end
      if (cmd.move) begin
        fill <= fill - CW'(1);
      end else if (cmd.store && !fill_full) begin
        fill <= fill + CW'(1);
      end
      if (cmd.scan_rd) begin
        scan_idx <= scan_idx + AW'(1);
      end else begin
        scan_idx <= '0;
      end
      cmp_pend <= cmd.scan_rd;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: input item, running minimum and result.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmd.acc) begin
      value_q <= din.value;
      final_q <= din.is_final;
    end
    if (cmp_pend && ((cmp_idx == '0) || (rd_data < best))) begin
      best     <= rd_data;
      best_idx <= cmp_idx;
    end
    if (cmd.out_load) begin
      out_value <= best;
      out_last  <= cmd.out_last;
    end
  end

  // The window never holds more entries than the store.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond store depth");

  // A removal only happens with a nonempty window.
  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> fill != '0)
    else $error("removal from an empty window");

  // The scan stays within the occupied entries.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> CW'(scan_idx) < fill)
    else $error("scan beyond occupied entries");

  // A result is never loaded over one that is still waiting.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || dout.ready))
    else $error("result register overwritten");

endmodule

@@ hdl/kws_controller.sv @@
// ----------------------------------------------------------------------------
// kws_controller: sequencer of the k-window stream sorter
// Steps each item through release, store and the final flush, and drives
// the datapath by commands while it reads back its status.
// ----------------------------------------------------------------------------
module kws_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  kws_pkg::kws_status_t status,
  output kws_pkg::kws_cmd_t    cmd
);
  import kws_pkg::*;

  kws_state_t state;
  kws_state_t state_next;
  logic       flush;
  logic       flush_next;

  // State and flush mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      flush <= flush_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    flush_next = flush;
    unique case (state)
      ST_IDLE: begin
        if (status.in_valid) begin
          state_next = status.need_release ? ST_SCAN : ST_STORE;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: state_next = ST_MOVE;
      ST_MOVE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          if (!flush) begin
            state_next = ST_STORE;
          end else if (status.fill_zero) begin
            state_next = ST_IDLE;
            flush_next = 1'b0;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_STORE: begin
        if (status.is_final) begin
          state_next = ST_SCAN;
          flush_next = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.acc      = status.in_valid;
      end
      ST_SCAN:  cmd.scan_rd = 1'b1;
      ST_TAIL:  cmd.tail_rd = 1'b1;
      ST_MOVE:  cmd.move    = 1'b1;
      ST_EMIT: begin
        cmd.out_load = status.out_free;
        cmd.out_last = flush && status.fill_zero;
      end
      ST_STORE: cmd.store = 1'b1;
      default:  cmd = '0;
    endcase
  end

  // Flush mode is entered only from the store of a final value.
  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(flush) |-> $past(state) == ST_STORE && $past(status.is_final))
    else $error("flush entered without a final value");

  // No new value is stored while the window is being flushed.
  a_no_store_in_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !flush)
    else $error("store during flush");

  // The last result of a flush returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> state == ST_IDLE && !flush)
    else $error("flush did not end after last result");

endmodule

@@ hdl/k_window_stream_sorter_unit.sv @@
// ----------------------------------------------------------------------------
// k_window_stream_sorter_unit: sorter for nearly sorted value streams
// Top level that joins the sequencer and the window datapath.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one signed 32-bit value per item, with is_final set on the
//   last value of a sequence. dout carries released values in ascending
//   window order; last_out marks the final result of a sequence.
//   cfg_wr_en/cfg_wr_data write window_k; the window holds window_k+1
//   values, at most WINDOW_DEPTH. Write it only while the block is idle.
// Sequence:
//   An item that only stores passes from IDLE to STORE. An item that
//   releases a value first runs the minimum search: it reads the window
//   memory one entry a cycle through its single read port, then the last
//   entry moves into the freed slot, the result is emitted and the item
//   is stored. A final item then flushes the window, one result per search.
//   Each result is loaded into the output register in EMIT, after TAIL and MOVE.
// Reset and stalls:
//   rst (synchronous) empties the window and clears window_k to zero.
//   When dout is stalled the sequencer holds before loading the next
//   result; a waiting result does not block the acceptance of an item
//   that only stores.
// ----------------------------------------------------------------------------
module k_window_stream_sorter_unit #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [kws_pkg::K_W-1:0] cfg_wr_data,
  kws_in_if.sink                  din,
  kws_out_if.source               dout
);
  import kws_pkg::*;

  kws_cmd_t    cmd;
  kws_status_t status;

  // Sequencer.
  kws_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Window store and minimum search.
  kws_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .din         (din),
    .dout        (dout)
  );

endmodule
